// ----- src/drt_pkg.sv -----
// drt_pkg: shared constants, codes and command/status types of the dirty rectangle tracker
// used by every other file of the block but drt_ram; depends on nothing
`timescale 1ns / 1ps

package drt_pkg;

  localparam int MAX_RECTS_DEF = 16;
  localparam int COORD_W       = 16;
  localparam int COUNT_W       = 5;
  localparam int ACTION_W      = 3;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_DAMAGE    = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_FULL = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN     = 2'd2;

  // action codes of a result
  localparam logic [ACTION_W-1:0] ACT_IGNORED   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_MERGED    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_APPENDED  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_COLLAPSED = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_EMITTED   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 16'd1920;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 16'd1080;

  // one stored rectangle, x in the low bits
  typedef struct packed {
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_MERGE,
    UPD_APPEND,
    UPD_FULL,
    UPD_CLEAR
  } upd_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CLIP,
    RES_FULL
  } res_sel_t;

  typedef struct packed {
    logic                load_in;
    logic                clip1;
    logic                clip2;
    logic                walk_start;
    logic                walk;
    logic                set_res;
    res_sel_t            res_sel;
    logic [ACTION_W-1:0] action;
    upd_t                upd;
    logic                emit;
    logic                idx_clr;
    logic                drain_emit;
  } drt_cmd_t;

  typedef struct packed {
    logic            outside;
    logic            hit;
    logic            walk_done;
    logic            list_full;
    logic            used_zero;
    logic            drain_last;
    logic            out_free;
  } drt_sts_t;

endpackage

// ----- src/drt_in_if.sv -----
// drt_in_if: request channel of the dirty rectangle tracker
// payload widths come from drt_pkg
`timescale 1ns / 1ps

interface drt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [drt_pkg::OP_W-1:0]      operation;
  logic signed [drt_pkg::COORD_W-1:0]   damage_x;
  logic signed [drt_pkg::COORD_W-1:0]   damage_y;
  logic        [drt_pkg::COORD_W-1:0]   damage_width;
  logic        [drt_pkg::COORD_W-1:0]   damage_height;

  modport source (
    output valid, operation, damage_x, damage_y, damage_width, damage_height,
    input  ready
  );
  modport sink (
    input  valid, operation, damage_x, damage_y, damage_width, damage_height,
    output ready
  );
endinterface

// ----- src/drt_out_if.sv -----
// drt_out_if: result channel of the dirty rectangle tracker
// payload widths come from drt_pkg
`timescale 1ns / 1ps

interface drt_out_if;
  logic                           valid;
  logic                           ready;
  logic [drt_pkg::ACTION_W-1:0]   action;
  logic [drt_pkg::COORD_W-1:0]    rect_x;
  logic [drt_pkg::COORD_W-1:0]    rect_y;
  logic [drt_pkg::COORD_W-1:0]    rect_width;
  logic [drt_pkg::COORD_W-1:0]    rect_height;
  logic [drt_pkg::COUNT_W-1:0]    rect_count;
  logic                           capture_pending;
  logic                           full_pending;
  logic                           last;

  modport source (
    output valid, action, rect_x, rect_y, rect_width, rect_height, rect_count,
           capture_pending, full_pending, last,
    input  ready
  );
  modport sink (
    input  valid, action, rect_x, rect_y, rect_width, rect_height, rect_count,
           capture_pending, full_pending, last,
    output ready
  );
endinterface

// ----- src/drt_ram.sv -----
// drt_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module drt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/drt_ctrl.sv -----
// drt_ctrl: sequencer of the dirty rectangle tracker
// drives drt_pkg::drt_cmd_t commands into the datapath and reads its status
`timescale 1ns / 1ps

module drt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [drt_pkg::OP_W-1:0]    in_op,
  output logic                        in_ready,
  output drt_pkg::drt_cmd_t           cmd,
  input  drt_pkg::drt_sts_t           sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLIP1  = 4'd1;
  localparam logic [3:0] S_CLIP2  = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_MERGE  = 4'd4;
  localparam logic [3:0] S_APPEND = 4'd5;
  localparam logic [3:0] S_FULL   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_DRD    = 4'd9;
  localparam logic [3:0] S_DOUT   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = drt_pkg::RES_ZERO;
    cmd.upd     = drt_pkg::UPD_NONE;
    cmd.action  = drt_pkg::ACT_IGNORED;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          priority if (in_op == drt_pkg::OP_DAMAGE) begin
            state_nxt = S_CLIP1;
          end else if (in_op == drt_pkg::OP_MARK_FULL) begin
            state_nxt = S_FULL;
          end else if (in_op == drt_pkg::OP_DRAIN) begin
            state_nxt = S_DRAIN;
          end else begin
            // unused operation code: plain ignored result
            cmd.set_res = 1'b1;
            state_nxt   = S_EMIT;
          end
        end
      end
      S_CLIP1: begin
        cmd.clip1 = 1'b1;
        state_nxt = S_CLIP2;
      end
      S_CLIP2: begin
        cmd.clip2 = 1'b1;
        if (sts.outside) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        priority if (sts.hit) begin
          state_nxt = S_MERGE;
        end else if (sts.walk_done) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_MERGE: begin
        cmd.upd     = drt_pkg::UPD_MERGE;
        cmd.set_res = 1'b1;
        cmd.res_sel = drt_pkg::RES_CLIP;
        cmd.action  = drt_pkg::ACT_MERGED;
        state_nxt   = S_EMIT;
      end
      S_APPEND: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = drt_pkg::RES_CLIP;
        if (sts.list_full) begin
          cmd.upd    = drt_pkg::UPD_FULL;
          cmd.action = drt_pkg::ACT_COLLAPSED;
        end else begin
          cmd.upd    = drt_pkg::UPD_APPEND;
          cmd.action = drt_pkg::ACT_APPENDED;
        end
        state_nxt = S_EMIT;
      end
      S_FULL: begin
        cmd.upd     = drt_pkg::UPD_FULL;
        cmd.set_res = 1'b1;
        cmd.res_sel = drt_pkg::RES_FULL;
        cmd.action  = drt_pkg::ACT_COLLAPSED;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (sts.used_zero) begin
          // empty list drains as one full-frame rectangle
          cmd.upd     = drt_pkg::UPD_CLEAR;
          cmd.set_res = 1'b1;
          cmd.res_sel = drt_pkg::RES_FULL;
          cmd.action  = drt_pkg::ACT_EMITTED;
          state_nxt   = S_EMIT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DRD;
        end
      end
      S_DRD: begin
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.drain_emit = 1'b1;
          if (sts.drain_last) begin
            cmd.upd   = drt_pkg::UPD_CLEAR;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/drt_dp.sv -----
// drt_dp: datapath of the dirty rectangle tracker: clip, compare-and-union unit,
// list state, rectangle memory (drt_ram) and output register; commanded by drt_ctrl
`timescale 1ns / 1ps

module drt_dp #(
  parameter int MAX_RECTS = drt_pkg::MAX_RECTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  drt_pkg::drt_cmd_t                     cmd,
  output drt_pkg::drt_sts_t                     sts,
  // configuration
  input  logic                                  cfg_we,
  input  logic [drt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [drt_pkg::COORD_W-1:0]           cfg_wdata,
  // request payload
  input  logic signed [drt_pkg::COORD_W-1:0]    in_damage_x,
  input  logic signed [drt_pkg::COORD_W-1:0]    in_damage_y,
  input  logic [drt_pkg::COORD_W-1:0]           in_damage_width,
  input  logic [drt_pkg::COORD_W-1:0]           in_damage_height,
  // result register
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [drt_pkg::ACTION_W-1:0]          out_action,
  output drt_pkg::box_t                         out_rect,
  output logic [drt_pkg::COUNT_W-1:0]           out_rect_count,
  output logic                                  out_capture_pending,
  output logic                                  out_full_pending,
  output logic                                  out_last
);

  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int CW    = drt_pkg::COORD_W;
  localparam int SW    = CW + 3;

  // configuration registers
  logic signed [CW-1:0] ox_r, oy_r;
  logic [CW-1:0]        fw_r, fh_r;

  // latched request
  logic signed [CW-1:0]     dx_r, dy_r;
  logic [CW-1:0]            dw_r, dh_r;

  // clip stage one
  logic signed [SW-1:0] rx_r, ry_r, rgt_r, bot_r;
  logic                 zero_r;
  logic signed [SW-1:0] dx_s, dy_s, ox_s, oy_s, dw_s, dh_s, fw_s, fh_s;

  // clipped rectangle and its far edges
  drt_pkg::box_t  c_r;
  logic [CW-1:0]  cr_r, cb_r;
  logic [CW-1:0]  cx, cy, cr, cb;
  logic           outside;

  // list state
  logic [CNT_W-1:0] used_r;
  logic             cap_r, full_r;
  logic [CNT_W-1:0] idx_r;
  logic             cmp_v_r;
  logic [IDX_W-1:0] cmp_idx_r;

  // compare-and-union unit
  drt_pkg::box_t  s, s_r, bnd, full_box, res_r;
  logic [CW:0]    sr, sb, sr_r, sb_r, x2, y2;
  logic [CW-1:0]  mx, my;
  logic           touch, hit;
  logic [drt_pkg::ACTION_W-1:0] action_r;

  // memory port
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [drt_pkg::BOX_W-1:0]   ram_wdata, ram_rdata;

  logic                        out_free;
  logic                        drain_last;

  assign full_box = '{h: fh_r, w: fw_r, y: '0, x: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      fw_r <= drt_pkg::FRAME_WIDTH_RST;
      fh_r <= drt_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drt_pkg::CFG_ORIGIN_X:     ox_r <= cfg_wdata;
        drt_pkg::CFG_ORIGIN_Y:     oy_r <= cfg_wdata;
        drt_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        drt_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx_r <= in_damage_x;
      dy_r <= in_damage_y;
      dw_r <= in_damage_width;
      dh_r <= in_damage_height;
    end
  end

  // shift by origin
  assign dx_s = {{3{dx_r[CW-1]}}, dx_r};
  assign dy_s = {{3{dy_r[CW-1]}}, dy_r};
  assign ox_s = {{3{ox_r[CW-1]}}, ox_r};
  assign oy_s = {{3{oy_r[CW-1]}}, oy_r};
  assign dw_s = $signed({3'b000, dw_r});
  assign dh_s = $signed({3'b000, dh_r});
  assign fw_s = $signed({3'b000, fw_r});
  assign fh_s = $signed({3'b000, fh_r});

  always_ff @(posedge clk) begin
    if (cmd.clip1) begin
      rx_r   <= dx_s - ox_s;
      ry_r   <= dy_s - oy_s;
      rgt_r  <= dx_s - ox_s + dw_s;
      bot_r  <= dy_s - oy_s + dh_s;
      zero_r <= (dw_r == '0) || (dh_r == '0);
    end
  end

  // clip to the frame
  assign outside = zero_r || (rgt_r <= 0) || (bot_r <= 0) ||
                   (rx_r >= fw_s) || (ry_r >= fh_s);
  assign cx = (rx_r < 0) ? '0 : rx_r[CW-1:0];
  assign cy = (ry_r < 0) ? '0 : ry_r[CW-1:0];
  assign cr = (rgt_r > fw_s) ? fw_r : rgt_r[CW-1:0];
  assign cb = (bot_r > fh_s) ? fh_r : bot_r[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clip2) begin
      c_r  <= '{h: cb - cy, w: cr - cx, y: cy, x: cx};
      cr_r <= cr;
      cb_r <= cb;
    end
  end

  // touch test against the entry read last cycle, shared edges count
  assign s     = ram_rdata;
  assign sr    = {1'b0, s.x} + {1'b0, s.w};
  assign sb    = {1'b0, s.y} + {1'b0, s.h};
  assign touch = (s.x <= cr_r) && ({1'b0, c_r.x} <= sr) &&
                 (s.y <= cb_r) && ({1'b0, c_r.y} <= sb);
  assign hit   = cmp_v_r && touch;

  always_ff @(posedge clk) begin
    if (cmd.walk && hit) begin
      s_r  <= s;
      sr_r <= sr;
      sb_r <= sb;
    end
  end

  // bounding box of matched entry and clipped rectangle
  assign x2  = (sr_r > {1'b0, cr_r}) ? sr_r : {1'b0, cr_r};
  assign y2  = (sb_r > {1'b0, cb_r}) ? sb_r : {1'b0, cb_r};
  assign mx  = (s_r.x < c_r.x) ? s_r.x : c_r.x;
  assign my  = (s_r.y < c_r.y) ? s_r.y : c_r.y;
  assign bnd = '{h: CW'(y2 - {1'b0, my}), w: CW'(x2 - {1'b0, mx}), y: my, x: mx};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_r;
    ram_wdata = bnd;
    unique case (cmd.upd)
      drt_pkg::UPD_MERGE: begin
        ram_we = 1'b1;
      end
      drt_pkg::UPD_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = used_r[IDX_W-1:0];
        ram_wdata = c_r;
      end
      drt_pkg::UPD_FULL: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = full_box;
      end
      default: ;
    endcase
  end

  drt_ram #(
    .WIDTH (drt_pkg::BOX_W),
    .DEPTH (MAX_RECTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cap_r  <= 1'b0;
      full_r <= 1'b0;
    end else begin
      unique case (cmd.upd)
        drt_pkg::UPD_MERGE: begin
          cap_r <= 1'b1;
        end
        drt_pkg::UPD_APPEND: begin
          used_r <= used_r + 1'b1;
          cap_r  <= 1'b1;
        end
        drt_pkg::UPD_FULL: begin
          used_r <= CNT_W'(1);
          cap_r  <= 1'b1;
          full_r <= 1'b1;
        end
        drt_pkg::UPD_CLEAR: begin
          used_r <= '0;
          cap_r  <= 1'b0;
          full_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign drain_last = (CNT_W'(idx_r + 1'b1) == used_r);

  // read index shared by the walk and the drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      if (cmd.walk_start || cmd.idx_clr) begin
        idx_r   <= '0;
        cmp_v_r <= 1'b0;
      end else if (cmd.walk) begin
        if (!hit && (idx_r != used_r)) begin
          idx_r   <= idx_r + 1'b1;
          cmp_v_r <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
      end else if (cmd.drain_emit && !drain_last) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && !hit && (idx_r != used_r)) begin
      cmp_idx_r <= idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      action_r <= cmd.action;
      unique case (cmd.res_sel)
        drt_pkg::RES_CLIP: res_r <= c_r;
        drt_pkg::RES_FULL: res_r <= full_box;
        default:           res_r <= '0;
      endcase
    end
  end

  // result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.drain_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_action          <= action_r;
      out_rect            <= res_r;
      out_rect_count      <= drt_pkg::COUNT_W'(used_r);
      out_capture_pending <= cap_r;
      out_full_pending    <= full_r;
      out_last            <= 1'b1;
    end else if (cmd.drain_emit) begin
      // drained entries show the state after the drain
      out_action          <= drt_pkg::ACT_EMITTED;
      out_rect            <= s;
      out_rect_count      <= '0;
      out_capture_pending <= 1'b0;
      out_full_pending    <= 1'b0;
      out_last            <= drain_last;
    end
  end

  always_comb begin
    sts            = '0;
    sts.outside    = outside;
    sts.hit        = hit;
    sts.walk_done  = !cmp_v_r && (idx_r == used_r);
    sts.list_full  = (used_r == CNT_W'(MAX_RECTS));
    sts.used_zero  = (used_r == '0);
    sts.drain_last = drain_last;
    sts.out_free   = out_free;
  end

endmodule

// ----- src/dirty_rectangle_tracker.sv -----
// dirty_rectangle_tracker: keeps a bounded list of dirty rectangles of a captured frame
// top level; instantiates drt_ctrl and drt_dp, uses drt_pkg, drt_in_if and drt_out_if
//
// requests come in on in_chan (valid/ready): damage a desktop rectangle, mark the whole
// frame dirty, or drain the list. results leave on out_chan (valid/ready); every request
// gives one result except a drain of a non-empty list, which gives one per stored
// rectangle, and last marks the final result of a request.
// the cfg_ port writes origin and frame size; write only while no request is in flight.
// one request is handled at a time. a damage request is first clipped to the frame; unless
// it is ignored, a single compare-and-union unit then walks the rectangle memory one entry
// a cycle through its one read port, merges into the first stored rectangle that it touches
// and otherwise appends or collapses. a drain reads each stored rectangle in turn and loads
// its result before it reads the next one. the block is ready for the next request in the
// cycle after the last result of the previous one loads.
// results sit in an output register; while the receiver stalls the block still takes
// and works one more request, then holds it until the register frees.
// reset empties the list, clears both flags and loads origin 0,0 and a 1920x1080 frame.
`timescale 1ns / 1ps

module dirty_rectangle_tracker #(
  parameter int MAX_RECTS = drt_pkg::MAX_RECTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  drt_in_if.sink                            in_chan,
  drt_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drt_pkg::COORD_W-1:0]       cfg_wdata
);

  drt_pkg::drt_cmd_t cmd;
  drt_pkg::drt_sts_t sts;
  drt_pkg::box_t     out_rect;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  drt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.operation),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  drt_dp #(
    .MAX_RECTS (MAX_RECTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_damage_x         (in_chan.damage_x),
    .in_damage_y         (in_chan.damage_y),
    .in_damage_width     (in_chan.damage_width),
    .in_damage_height    (in_chan.damage_height),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_action          (out_chan.action),
    .out_rect            (out_rect),
    .out_rect_count      (out_chan.rect_count),
    .out_capture_pending (out_chan.capture_pending),
    .out_full_pending    (out_chan.full_pending),
    .out_last            (out_chan.last)
  );

  assign out_chan.rect_x      = out_rect.x;
  assign out_chan.rect_y      = out_rect.y;
  assign out_chan.rect_width  = out_rect.w;
  assign out_chan.rect_height = out_rect.h;

  // output register is never overwritten while a result still waits
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.drain_emit) |-> sts.out_free)
    else $error("result loaded over a pending result");

  // one request at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while busy");

  // appending only with room in the list
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd == drt_pkg::UPD_APPEND) |-> !sts.list_full)
    else $error("append into a full list");

  // nothing leaves right after reset
  assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

endmodule

// ----- tb/sv/drt_rect_checker.sv -----
// drt_rect_checker: watches the request, result and cfg ports of the dirty rectangle tracker,
// keeps its own copy of the rectangle list and compares every result in order
// depends on drt_pkg, drt_in_if and drt_out_if
`timescale 1ns / 1ps

module drt_rect_checker
  import drt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  drt_in_if                    req_mon,
  drt_out_if                   res_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  output int                   fail_count,
  output int                   open_results
);

  localparam int LIST_DEPTH = MAX_RECTS_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    box_t                rect;
    logic [COUNT_W-1:0]  count;
    logic                capture;
    logic                full;
    logic                last;
  } rect_result_t;

  box_t                      rect_list [LIST_DEPTH];
  int                        rects_held;
  logic                      capture_set;
  logic                      full_due;
  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic [COORD_W-1:0]        frame_w;
  logic [COORD_W-1:0]        frame_h;
  rect_result_t              pending_results [$];
  int                        mismatches;

  function automatic box_t frame_box();
    box_t b;
    b.x = '0;
    b.y = '0;
    b.w = frame_w;
    b.h = frame_h;
    return b;
  endfunction

  // shared edges count as touching
  function automatic bit boxes_meet(box_t a, box_t b);
    int a_r, a_b, b_r, b_b;
    a_r = int'(a.x) + int'(a.w);
    a_b = int'(a.y) + int'(a.h);
    b_r = int'(b.x) + int'(b.w);
    b_b = int'(b.y) + int'(b.h);
    return int'(a.x) <= b_r && int'(b.x) <= a_r && int'(a.y) <= b_b && int'(b.y) <= a_b;
  endfunction

  function automatic box_t bounding_box(box_t a, box_t b);
    box_t r;
    int   a_r, a_b, b_r, b_b;
    a_r = int'(a.x) + int'(a.w);
    a_b = int'(a.y) + int'(a.h);
    b_r = int'(b.x) + int'(b.w);
    b_b = int'(b.y) + int'(b.h);
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.w = COORD_W'(((a_r > b_r) ? a_r : b_r) - int'(r.x));
    r.h = COORD_W'(((a_b > b_b) ? a_b : b_b) - int'(r.y));
    return r;
  endfunction

  function automatic string describe(rect_result_t r);
    return $sformatf("act=%0d x=%0d y=%0d w=%0d h=%0d count=%0d cap=%0b full=%0b last=%0b",
                     r.action, r.rect.x, r.rect.y, r.rect.w, r.rect.h, r.count,
                     r.capture, r.full, r.last);
  endfunction

  // status fields show the list after the request
  task automatic queue_result(logic [ACTION_W-1:0] action, box_t rect, logic last);
    rect_result_t r;
    r.action  = action;
    r.rect    = rect;
    r.count   = COUNT_W'(rects_held);
    r.capture = capture_set;
    r.full    = full_due;
    r.last    = last;
    pending_results.push_back(r);
  endtask

  task automatic track_request(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] dx,
                               logic signed [COORD_W-1:0] dy, logic [COORD_W-1:0] dw,
                               logic [COORD_W-1:0] dh);
    int   rx, ry, rgt, bot, fw, fh, held, i;
    box_t clip, none;
    none = '0;
    fw   = int'(frame_w);
    fh   = int'(frame_h);
    case (op)
      OP_DAMAGE: begin
        rx  = int'(dx) - int'(org_x);
        ry  = int'(dy) - int'(org_y);
        rgt = rx + int'(dw);
        bot = ry + int'(dh);
        if (dw == '0 || dh == '0 || rgt <= 0 || bot <= 0 || rx >= fw || ry >= fh) begin
          queue_result(ACT_IGNORED, none, 1'b1);
          return;
        end
        if (rx < 0) rx = 0;
        if (ry < 0) ry = 0;
        if (rgt > fw) rgt = fw;
        if (bot > fh) bot = fh;
        clip.x = COORD_W'(rx);
        clip.y = COORD_W'(ry);
        clip.w = COORD_W'(rgt - rx);
        clip.h = COORD_W'(bot - ry);
        capture_set = 1'b1;
        // first stored rectangle that meets the clipped one absorbs it
        for (i = 0; i < rects_held; i++) begin
          if (boxes_meet(rect_list[i], clip)) begin
            rect_list[i] = bounding_box(rect_list[i], clip);
            queue_result(ACT_MERGED, clip, 1'b1);
            return;
          end
        end
        if (rects_held < LIST_DEPTH) begin
          rect_list[rects_held] = clip;
          rects_held++;
          queue_result(ACT_APPENDED, clip, 1'b1);
        end else begin
          rect_list[0] = frame_box();
          rects_held   = 1;
          full_due     = 1'b1;
          queue_result(ACT_COLLAPSED, clip, 1'b1);
        end
      end
      OP_MARK_FULL: begin
        rect_list[0] = frame_box();
        rects_held   = 1;
        capture_set  = 1'b1;
        full_due     = 1'b1;
        queue_result(ACT_COLLAPSED, frame_box(), 1'b1);
      end
      OP_DRAIN: begin
        held        = rects_held;
        rects_held  = 0;
        capture_set = 1'b0;
        full_due    = 1'b0;
        if (held == 0) queue_result(ACT_EMITTED, frame_box(), 1'b1);
        for (i = 0; i < held; i++) queue_result(ACT_EMITTED, rect_list[i], i == held - 1);
      end
      default: begin
        queue_result(ACT_IGNORED, none, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    rect_result_t got, want;
    if (!rst_n) begin
      rects_held  = 0;
      capture_set = 1'b0;
      full_due    = 1'b0;
      org_x       = '0;
      org_y       = '0;
      frame_w     = FRAME_WIDTH_RST;
      frame_h     = FRAME_HEIGHT_RST;
      fail_count  = 0;
      mismatches  = 0;
      pending_results.delete();
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (res_mon.valid && res_mon.ready) begin
        got.action  = res_mon.action;
        got.rect.x  = res_mon.rect_x;
        got.rect.y  = res_mon.rect_y;
        got.rect.w  = res_mon.rect_width;
        got.rect.h  = res_mon.rect_height;
        got.count   = res_mon.rect_count;
        got.capture = res_mon.capture_pending;
        got.full    = res_mon.full_pending;
        got.last    = res_mon.last;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (mismatches < REPORT_MAX) $display("unexpected result: %s", describe(got));
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.action !== want.action || got.rect.x !== want.rect.x ||
              got.rect.y !== want.rect.y || got.rect.w !== want.rect.w ||
              got.rect.h !== want.rect.h || got.count !== want.count ||
              got.capture !== want.capture || got.full !== want.full ||
              got.last !== want.last) begin
            fail_count++;
            if (mismatches < REPORT_MAX)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       describe(want), describe(got));
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X:     org_x   = cfg_wdata;
          CFG_ORIGIN_Y:     org_y   = cfg_wdata;
          CFG_FRAME_WIDTH:  frame_w = cfg_wdata;
          CFG_FRAME_HEIGHT: frame_h = cfg_wdata;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        track_request(req_mon.operation, req_mon.damage_x, req_mon.damage_y,
                      req_mon.damage_width, req_mon.damage_height);
    end
    open_results = pending_results.size();
  end

endmodule

// ----- tb/sv/tb_dirty_rectangle_tracker.sv -----
// tb_dirty_rectangle_tracker: drives damage, mark-full, drain and spare requests and cfg
// writes into the dirty rectangle tracker with bursty requests and a stalling receiver
// depends on drt_pkg, drt_in_if, drt_out_if, dirty_rectangle_tracker and drt_rect_checker
`timescale 1ns / 1ps

module tb_dirty_rectangle_tracker;
  import drt_pkg::*;

  localparam int RESET_CYCLES     = 6;
  localparam int QUIET_LIMIT      = 2000;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 8;
  localparam int DRAIN_TAIL       = 40;
  localparam int PHASES           = 7;
  localparam int RANDOM_PER_PHASE = 20;
  localparam int LIST_DEPTH       = MAX_RECTS_DEF;

  // operation code the block does not define
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;
  int                   fail_count;
  int                   open_results;
  bit                   hold_req;
  bit                   steady_send;
  int                   burst_left;
  int                   org_x, org_y, fw, fh;

  drt_in_if  in_ch ();
  drt_out_if out_ch ();

  dirty_rectangle_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  drt_rect_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_mon      (in_ch),
    .res_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ends the run when neither channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_dirty_rectangle_tracker failed");
    $finish;
  end

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin
    bit hold_ack;
    int hold_left, mode, mode_left, tick;
    hold_ack     = 1'b0;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // one request; valid stays up across a burst and drops only in a gap
  task automatic issue(logic [OP_W-1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                       logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.damage_x      <= x;
    in_ch.damage_y      <= y;
    in_ch.damage_width  <= w;
    in_ch.damage_height <= h;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic write_config(int ox, int oy, int w, int h);
    put_reg(CFG_ORIGIN_X, COORD_W'(ox));
    put_reg(CFG_ORIGIN_Y, COORD_W'(oy));
    put_reg(CFG_FRAME_WIDTH, COORD_W'(w));
    put_reg(CFG_FRAME_HEIGHT, COORD_W'(h));
    cfg_we <= 1'b0;
    org_x = ox;
    org_y = oy;
    fw    = w;
    fh    = h;
  endtask

  // no request in flight and the block back at rest
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // damage near and inside the frame, mostly small
  task automatic random_damage();
    int rx, ry, w, h;
    rx = int'($urandom_range(0, fw + 16)) - 8;
    ry = int'($urandom_range(0, fh + 16)) - 8;
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(1, fw);
      h = $urandom_range(1, fh);
    end else begin
      w = $urandom_range(1, (fw > 6) ? fw / 6 : 1);
      h = $urandom_range(1, (fh > 6) ? fh / 6 : 1);
    end
    issue(OP_DAMAGE, COORD_W'(org_x + rx), COORD_W'(org_y + ry), COORD_W'(w), COORD_W'(h));
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 64) random_damage();
    else if (pick < 72)
      issue(OP_DAMAGE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
            COORD_W'($urandom));
    else if (pick < 77) begin
      if ($urandom_range(0, 1) == 0)
        issue(OP_DAMAGE, COORD_W'($urandom), COORD_W'($urandom), '0, COORD_W'($urandom));
      else
        issue(OP_DAMAGE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), '0);
    end
    else if (pick < 82)
      issue(OP_MARK_FULL, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
            COORD_W'($urandom));
    else if (pick < 97)
      issue(OP_DRAIN, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
            COORD_W'($urandom));
    else
      issue(OP_SPARE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
            COORD_W'($urandom));
  endtask

  // grid of separated rectangles: fills the list, overflows it, then merges into the frame
  task automatic fill_list();
    int k;
    issue(OP_DRAIN, '0, '0, '0, '0);
    for (k = 0; k <= LIST_DEPTH + 1; k++)
      issue(OP_DAMAGE, COORD_W'(org_x + (k % 8) * (fw / 8)), COORD_W'(org_y + (k / 8) * (fh / 4)),
            COORD_W'(fw / 16), COORD_W'(fh / 8));
  endtask

  initial begin
    int p;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_ORIGIN_X;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_DAMAGE;
    in_ch.damage_x      = '0;
    in_ch.damage_y      = '0;
    in_ch.damage_width  = '0;
    in_ch.damage_height = '0;
    hold_req            = 1'b0;
    steady_send         = 1'b0;
    burst_left          = 0;
    org_x               = 0;
    org_y               = 0;
    fw                  = int'(FRAME_WIDTH_RST);
    fh                  = int'(FRAME_HEIGHT_RST);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on the reset frame
    issue(OP_DRAIN, '0, '0, '0, '0);
    issue(OP_DAMAGE, 16'd10, 16'd10, '0, 16'd10);
    issue(OP_DAMAGE, 16'd10, 16'd10, 16'd10, '0);
    issue(OP_DAMAGE, COORD_W'(-100), 16'd0, 16'd100, 16'd5);
    issue(OP_DAMAGE, 16'd1920, 16'd0, 16'd5, 16'd5);
    issue(OP_DAMAGE, 16'd0, 16'd1080, 16'd5, 16'd5);
    issue(OP_DAMAGE, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    issue(OP_DAMAGE, 16'd100, 16'd100, 16'd10, 16'd10);
    issue(OP_DRAIN, '0, '0, '0, '0);
    issue(OP_DAMAGE, 16'd0, 16'd0, 16'd10, 16'd10);
    issue(OP_DAMAGE, 16'd10, 16'd0, 16'd5, 16'd5);
    issue(OP_DAMAGE, 16'd16, 16'd0, 16'd5, 16'd5);
    issue(OP_DAMAGE, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    issue(OP_DAMAGE, 16'd1900, 16'd1070, 16'hFFFF, 16'hFFFF);
    issue(OP_DRAIN, '0, '0, '0, '0);
    issue(OP_MARK_FULL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(OP_DAMAGE, 16'd5, 16'd5, 16'd1, 16'd1);
    issue(OP_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(OP_DRAIN, '0, '0, '0, '0);
    issue(OP_DRAIN, '0, '0, '0, '0);
    issue(OP_DAMAGE, COORD_W'(-5), COORD_W'(-5), 16'd10, 16'd10);
    issue(OP_DAMAGE, COORD_W'(-1), COORD_W'(-1), 16'd1, 16'd1);

    // random part; the list is left as it is across register changes
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: write_config(0, 0, 1920, 1080);
        1: write_config(-32768, -32768, 65535, 65535);
        2: write_config(32767, 32767, 1, 1);
        3: write_config(100, -50, 64, 48);
        4: write_config(-1000, 500, 800, 600);
        5: write_config(0, 0, 65535, 1);
        default: write_config(1234, -4321, 4096, 2160);
      endcase
      steady_send = (p == 2 || p == 5);
      // long receiver hold-off while requests keep coming
      if (p == 3) hold_req = ~hold_req;
      if (fw >= 16 && fh >= 16 && p != 4) fill_list();
      repeat (RANDOM_PER_PHASE) random_item();
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
    if (fail_count == 0 && open_results == 0)
      $display("tb_dirty_rectangle_tracker passed");
    else
      $display("tb_dirty_rectangle_tracker failed");
    $finish;
  end

endmodule
